// File: hw/rtl/cartesian_to_polar_color_core_macros.svh
// ----------------------------------------------------------------------------
// cartesian_to_polar_color_core_macros.svh
// assertion macros for the cartesian to polar color core
// ----------------------------------------------------------------------------
`ifndef CARTESIAN_TO_POLAR_COLOR_CORE_MACROS_SVH
`define CARTESIAN_TO_POLAR_COLOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define C2P_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c2p assertion failed");
// next-cycle implication
`define C2P_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c2p assertion failed");
`else
`define C2P_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define C2P_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/c2p_pkg.sv
// ----------------------------------------------------------------------------
// c2p_pkg
// shared constants, angle table and types of the cartesian to polar core
// ----------------------------------------------------------------------------
package c2p_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int GUARD_BITS       = 4;
    localparam int ANGLE_LEN        = 24;
    localparam int HUE_W            = 16;
    localparam int GAIN_W           = 24;

    // about 0.6072455 in q0.24
    localparam logic [GAIN_W-1:0] GAIN_Q24      = 24'd10187889;
    localparam logic [HUE_W-1:0]  HUE_FULL_TURN = 16'd46080;
    // half a turn of the 32-bit binary angle
    localparam logic [31:0]       ANGLE_HALF    = 32'h8000_0000;

    // control that travels alongside each word
    typedef struct packed {
        logic valid;
        logic zero;   // both axes zero
    } t_ctl;

    // atan(2^-i), full turn = 2^32
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2F9;
            5'd15:   v = 32'h0000517C;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A2F;
            5'd19:   v = 32'h00000517;
            5'd20:   v = 32'h0000028B;
            5'd21:   v = 32'h00000145;
            5'd22:   v = 32'h000000A2;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/c2p_cell.sv
// ----------------------------------------------------------------------------
// c2p_cell
// one registered cordic vectoring micro-rotation
// ----------------------------------------------------------------------------
module c2p_cell #(
    parameter int XW    = 23,
    parameter int LW    = 16,
    parameter int STEP  = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  c2p_pkg::t_ctl        i_ctl,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic [31:0]          i_z,
    input  logic [LW-1:0]        i_l,
    output c2p_pkg::t_ctl        o_ctl,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic [31:0]          o_z,
    output logic [LW-1:0]        o_l
);
    import c2p_pkg::*;

    localparam logic [31:0] ATAN = atan_entry(5'(STEP));

    logic signed [XW-1:0] xs, ys, n_x, n_y;
    logic [31:0]          n_z;
    t_ctl                 r_ctl;
    logic signed [XW-1:0] r_x, r_y;
    logic [31:0]          r_z;
    logic [LW-1:0]        r_l;

    assign xs = i_x >>> STEP;
    assign ys = i_y >>> STEP;

    // rotate toward the positive first axis
    always_comb begin
        if (!i_y[XW-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ATAN;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            r_l <= i_l;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_l   = r_l;

endmodule

// File: hw/rtl/c2p_post.sv
// ----------------------------------------------------------------------------
// c2p_post
// gain correction, rounding and saturation of chroma, hue scaling
// ----------------------------------------------------------------------------
module c2p_post #(
    parameter int XW = 23,
    parameter int LW = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  c2p_pkg::t_ctl               i_ctl,
    input  logic signed [XW-1:0]        i_x,
    input  logic [31:0]                 i_z,
    input  logic [LW-1:0]               i_l,
    output c2p_pkg::t_ctl               o_ctl,
    output logic [LW-1:0]               o_chroma,
    output logic [c2p_pkg::HUE_W-1:0]   o_hue,
    output logic [LW-1:0]               o_l
);
    import c2p_pkg::*;

    // x is never negative after the cordic steps
    localparam int XU  = XW - 1;
    localparam int LO  = XU / 2;
    localparam int HI  = XU - LO;
    localparam int SW  = XU + GAIN_W + 1;
    localparam int CW  = SW - (GAIN_W + GUARD_BITS);
    localparam int HPW = 32 + HUE_W;

    // stage 1: partial products
    t_ctl                   r_ctl1;
    logic [LO+GAIN_W-1:0]   r_p_lo;
    logic [HI+GAIN_W-1:0]   r_p_hi;
    logic [HPW-1:0]         r_p_hue;
    logic [LW-1:0]          r_l1;

    // stage 2: results
    t_ctl                   r_ctl2;
    logic [LW-1:0]          r_chroma;
    logic [HUE_W-1:0]       r_hue;
    logic [LW-1:0]          r_l2;

    logic [SW-1:0]          sum_c;
    logic [CW-1:0]          chroma_full;
    logic [HPW:0]           sum_h;
    logic [HUE_W:0]         hue_full;
    logic [LW-1:0]          n_chroma;
    logic [HUE_W-1:0]       n_hue;

    always_comb begin
        sum_c = (SW'(r_p_hi) << LO) + SW'(r_p_lo)
              + (SW'(1) << (GAIN_W - 1 + GUARD_BITS));
        chroma_full = sum_c[SW-1:GAIN_W+GUARD_BITS];
        if (r_ctl1.zero) begin
            n_chroma = '0;
        end else if (|chroma_full[CW-1:LW]) begin
            n_chroma = '1;
        end else begin
            n_chroma = chroma_full[LW-1:0];
        end

        sum_h    = {1'b0, r_p_hue} + (HPW+1)'(ANGLE_HALF);
        hue_full = sum_h[HPW:32];
        if (r_ctl1.zero || hue_full >= {1'b0, HUE_FULL_TURN}) begin
            n_hue = '0;
        end else begin
            n_hue = hue_full[HUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else if (i_en) begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_lo   <= i_x[LO-1:0] * GAIN_Q24;
            r_p_hi   <= i_x[XU-1:LO] * GAIN_Q24;
            r_p_hue  <= i_z * HUE_FULL_TURN;
            r_l1     <= i_l;
            r_chroma <= n_chroma;
            r_hue    <= n_hue;
            r_l2     <= r_l1;
        end
    end

    assign o_ctl    = r_ctl2;
    assign o_chroma = r_chroma;
    assign o_hue    = r_hue;
    assign o_l      = r_l2;

endmodule

// File: hw/rtl/cartesian_to_polar_color_core.sv
// a word passes the pre-rotation register, the cell row, both post stages and the output register
// throughput: one word per cycle unless a skid word is held; set by the CORDIC_STEPS rotation cells
// each cell does one micro-rotation, so the row holds that many words in flight
// a two-entry output register and skid buffer keep input ready registered
// reset: synchronous, active low; clears valid and control flags only, payload is not reset
`include "cartesian_to_polar_color_core_macros.svh"
// ----------------------------------------------------------------------------
// cartesian_to_polar_color_core
// lightness/opponent-axis color to lightness, chroma and hue by cordic vectoring
// ----------------------------------------------------------------------------
module cartesian_to_polar_color_core #(
    parameter int CORDIC_STEPS = c2p_pkg::CORDIC_STEPS_DEF,
    parameter int SAMPLE_WIDTH = c2p_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    // slave side
    input  logic                                               i_s_tvalid,
    output logic                                               o_s_tready,
    // lightness_in, axis_a, axis_b (low bit up)
    input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]                i_s_tdata,
    // master side
    output logic                                               o_m_tvalid,
    input  logic                                               i_m_tready,
    // lightness_out, chroma, hue (low bit up)
    output logic [((2*SAMPLE_WIDTH+c2p_pkg::HUE_W+7)/8)*8-1:0] o_m_tdata
);
    import c2p_pkg::*;

    localparam int W      = SAMPLE_WIDTH;
    // sign, guard bits and cordic growth of about 2.3
    localparam int XW     = W + GUARD_BITS + 3;
    localparam int N      = CORDIC_STEPS;
    localparam int OUT_DW = ((2*W + HUE_W + 7)/8)*8;
    localparam int OUT_PW = 2*W + HUE_W;

    // ---------------------------------------------------------------- unpack
    logic [W-1:0] in_l, in_a, in_b;
    assign in_l = i_s_tdata[W-1:0];
    assign in_a = i_s_tdata[2*W-1:W];
    assign in_b = i_s_tdata[3*W-1:2*W];

    // whole pipeline moves together; it stops only while the skid word is held
    logic r_skid_valid;
    logic en;
    assign en         = !r_skid_valid;
    assign o_s_tready = en;

    // ---------------------------------------------------------- pre-rotation
    // a negative first axis is turned by half a turn before the cell row
    logic signed [XW-1:0] a_ext, b_ext, n_x0, n_y0;
    logic [31:0]          n_z0;
    t_ctl                 n_ctl0;

    always_comb begin
        a_ext = {{(XW-W){in_a[W-1]}}, in_a};
        b_ext = {{(XW-W){in_b[W-1]}}, in_b};
        if (in_a[W-1]) begin
            n_x0 = (-a_ext) <<< GUARD_BITS;
            n_y0 = (-b_ext) <<< GUARD_BITS;
            n_z0 = ANGLE_HALF;
        end else begin
            n_x0 = a_ext <<< GUARD_BITS;
            n_y0 = b_ext <<< GUARD_BITS;
            n_z0 = '0;
        end
        n_ctl0.valid = i_s_tvalid;
        n_ctl0.zero  = (in_a == '0) && (in_b == '0);
    end

    // chain taps: index 0 is the pre-rotation register, index k is cell k-1
    t_ctl                 ctl_c [0:N];
    logic signed [XW-1:0] x_c   [0:N];
    logic signed [XW-1:0] y_c   [0:N];
    logic [31:0]          z_c   [0:N];
    logic [W-1:0]         l_c   [0:N];

    t_ctl                 r_ctl0;
    logic signed [XW-1:0] r_x0, r_y0;
    logic [31:0]          r_z0;
    logic [W-1:0]         r_l0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else if (en) begin
            r_ctl0 <= n_ctl0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x0 <= n_x0;
            r_y0 <= n_y0;
            r_z0 <= n_z0;
            r_l0 <= in_l;
        end
    end

    assign ctl_c[0] = r_ctl0;
    assign x_c[0]   = r_x0;
    assign y_c[0]   = r_y0;
    assign z_c[0]   = r_z0;
    assign l_c[0]   = r_l0;

    // -------------------------------------------------------------- cell row
    // one micro-rotation per cell, each cell hands its word on every cycle that the pipeline is not frozen
    for (genvar k = 0; k < N; k++) begin : g_cell
        c2p_cell #(
            .XW   (XW),
            .LW   (W),
            .STEP (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (ctl_c[k]),
            .i_x     (x_c[k]),
            .i_y     (y_c[k]),
            .i_z     (z_c[k]),
            .i_l     (l_c[k]),
            .o_ctl   (ctl_c[k+1]),
            .o_x     (x_c[k+1]),
            .o_y     (y_c[k+1]),
            .o_z     (z_c[k+1]),
            .o_l     (l_c[k+1])
        );
    end

    // ------------------------------------------------------- post-processing
    t_ctl             post_ctl;
    logic [W-1:0]     post_chroma;
    logic [HUE_W-1:0] post_hue;
    logic [W-1:0]     post_l;

    c2p_post #(
        .XW (XW),
        .LW (W)
    ) u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_ctl    (ctl_c[N]),
        .i_x      (x_c[N]),
        .i_z      (z_c[N]),
        .i_l      (l_c[N]),
        .o_ctl    (post_ctl),
        .o_chroma (post_chroma),
        .o_hue    (post_hue),
        .o_l      (post_l)
    );

    // ------------------------------------------------ output register + skid
    logic [OUT_PW-1:0] post_word;
    logic              r_out_valid;
    logic [OUT_PW-1:0] r_out_word;
    logic [OUT_PW-1:0] r_skid_word;

    assign post_word = {post_hue, post_chroma, post_l};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // pipeline frozen, drain the skid word once the output is taken
            if (i_m_tready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || i_m_tready) begin
            r_out_valid <= post_ctl.valid;
        end else if (post_ctl.valid) begin
            // output stalled and a word arrives: park it
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_m_tready) begin
                r_out_word <= r_skid_word;
            end
        end else if (!r_out_valid || i_m_tready) begin
            r_out_word <= post_word;
        end else begin
            r_skid_word <= post_word;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DW'(r_out_word);

    // ------------------------------------------------------------ assertions
    logic [HUE_W-1:0] out_hue;
    assign out_hue = r_out_word[OUT_PW-1:2*W];

    // a parked word always sits behind a held output word
    `C2P_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    // the skid fills only when the output word was stalled
    `C2P_ASSERT_IMPL(a_skid_fill_cause, i_clk, i_rst_n, $rose(r_skid_valid),
                     $past(r_out_valid) && !$past(i_m_tready))
    // draining the skid leaves a valid output word
    `C2P_ASSERT_NEXT(a_skid_drain, i_clk, i_rst_n, r_skid_valid && i_m_tready, r_out_valid)
    // hue is always wrapped below a full turn
    `C2P_ASSERT_IMPL(a_hue_range, i_clk, i_rst_n, r_out_valid, out_hue < HUE_FULL_TURN)

endmodule
